// ===== hw/rtl/tct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Throughput correlation tracker package
// Shared widths, constants and types of the tracker and its square root unit.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int TimeW  = 32;
  localparam int CountW = 48;
  localparam int SumW   = 64;
  localparam int RadW   = 2 * SumW;
  localparam int NumW   = CountW + 20;
  localparam int UsecW  = 20;
  localparam int AddrW  = 3;

  localparam logic [UsecW-1:0] UsecPerSec = 20'd1000000;

  // Register index, taken from paddr[2].
  localparam logic RegTimeShift  = 1'b0;
  localparam logic RegCountShift = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// ===== hw/rtl/throughput_correlation_tracker.sv =====
`timescale 1ns / 1ps
// Steps: the origin sample goes straight to the done state; every later sample runs
// the multiplies, the 64-step product, the 64-step square root, the correlation
// division, the throughput multiply and the 68-step throughput division, bit by bit
// and one after the other, then the output register. A clamp to one skips the
// correlation division, a zero divisor all that follow; samples are taken only when idle.
// Reset clears both shift registers, the origin and the three sums.
// ----------------------------------------------------------------------------
// Throughput correlation tracker
// Accumulates squared and cross sums of time and count deltas and reports the
// uncentered correlation and events per second for every sample.
// ----------------------------------------------------------------------------
module throughput_correlation_tracker #(
  parameter int DELTA_BITS = 24,
  parameter int FRAC_BITS  = 16,
  localparam int CorrW = FRAC_BITS + 1,
  localparam int OutW  = ((CorrW + 48 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [79:0]                 s_axis_tdata,   // time_us, event_count
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OutW-1:0]             m_axis_tdata,   // correlation, throughput, zero pad
  output logic [0:0]                  m_axis_tuser,   // valid_res
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tct_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int SumW  = tct_pkg::SumW;
  localparam int NumW  = tct_pkg::NumW;
  localparam logic [CorrW-1:0] CorrOne = CorrW'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_PROD, S_SQRT, S_CORR, S_TMUL, S_TDIV, S_DONE
  } state_e;

  state_e                   state_q;
  logic [6:0]               cnt_q;
  logic [4:0]               ts_q;
  logic [5:0]               cs_q;
  logic                     have_origin_q;
  logic [31:0]              ot_q;
  logic [47:0]              oc_q;
  logic [31:0]              dt_q;
  logic [47:0]              de_q;
  logic [DELTA_BITS-1:0]    x_q, y_q;
  logic [2*DELTA_BITS-1:0]  prod_q;
  logic [SumW-1:0]          sxx_q, sxy_q, syy_q;
  logic [SumW-1:0]          acc_hi_q, acc_lo_q;
  logic [SumW-1:0]          frem_q;
  logic [CorrW-1:0]         corr_q;
  logic [NumW-1:0]          num_q;
  logic [31:0]              drem_q;
  logic [47:0]              thr_q;
  logic                     vres_q;
  logic                     sq_start_q;
  logic                     m_valid_q;
  logic [CorrW-1:0]         m_corr_q;
  logic [47:0]              m_thr_q;
  logic                     m_vres_q;

  tct_pkg::sqrt_stat_t      sq_stat;
  logic [SumW-1:0]          sq_root;

  logic                     in_acc, cfg_wr, out_load;
  logic [31:0]              dt_c, dt_sh;
  logic [47:0]              de_c, de_sh;
  logic [DELTA_BITS-1:0]    x_c, y_c, mul_a, mul_b;
  logic [2*DELTA_BITS-1:0]  mul_p;
  logic [SumW-1:0]          sadd_a, sadd_r;
  logic [SumW:0]            sadd_s;
  logic [SumW:0]            psum, frem2;
  logic [32:0]              drem2;
  logic                     dge;
  logic [NumW-1:0]          num_nx;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == S_IDLE);
  assign pready        = 1'b1;
  assign prdata = (paddr[2] == tct_pkg::RegCountShift) ? {26'd0, cs_q} : {27'd0, ts_q};

  // Deltas from the origin, shifted and saturated.
  assign dt_c  = s_axis_tdata[31:0] - ot_q;
  assign de_c  = s_axis_tdata[79:32] - oc_q;
  assign dt_sh = dt_c >> ts_q;
  assign de_sh = de_c >> cs_q;
  assign x_c   = (|(dt_sh >> DELTA_BITS)) ? '1 : dt_sh[DELTA_BITS-1:0];
  assign y_c   = (|(de_sh >> DELTA_BITS)) ? '1 : de_sh[DELTA_BITS-1:0];

  // One shared multiplier; its product is registered and added to a sum in the next cycle.
  assign mul_a = (cnt_q == 7'd2) ? y_q : x_q;
  assign mul_b = (cnt_q == 7'd0) ? x_q : y_q;
  assign mul_p = (2*DELTA_BITS)'(mul_a) * (2*DELTA_BITS)'(mul_b);

  always_comb begin
    case (cnt_q)
      7'd1:    sadd_a = sxx_q;
      7'd2:    sadd_a = sxy_q;
      default: sadd_a = syy_q;
    endcase
  end
  assign sadd_s = {1'b0, sadd_a} + (SumW + 1)'(prod_q);
  assign sadd_r = sadd_s[SumW] ? '1 : sadd_s[SumW-1:0];

  // Shift-add step of Sxx * Syy, multiplier bits consumed from acc_lo_q.
  assign psum  = {1'b0, acc_hi_q} + (acc_lo_q[0] ? {1'b0, sxx_q} : '0);
  assign frem2 = {frem_q, 1'b0};
  assign drem2 = {drem_q, num_q[NumW-1]};
  assign dge   = drem2 >= {1'b0, dt_q};
  assign num_nx = {num_q[NumW-2:0], dge};

  tct_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_q),
    .rad_i   ({acc_hi_q, acc_lo_q}),
    .stat_o  (sq_stat),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      ts_q          <= '0;
      cs_q          <= '0;
      have_origin_q <= 1'b0;
      ot_q          <= '0;
      oc_q          <= '0;
      dt_q          <= '0;
      de_q          <= '0;
      x_q           <= '0;
      y_q           <= '0;
      prod_q        <= '0;
      sxx_q         <= '0;
      sxy_q         <= '0;
      syy_q         <= '0;
      acc_hi_q      <= '0;
      acc_lo_q      <= '0;
      frem_q        <= '0;
      corr_q        <= '0;
      num_q         <= '0;
      drem_q        <= '0;
      thr_q         <= '0;
      vres_q        <= 1'b0;
      sq_start_q    <= 1'b0;
      m_valid_q     <= 1'b0;
      m_corr_q      <= '0;
      m_thr_q       <= '0;
      m_vres_q      <= 1'b0;
    end else begin
      sq_start_q <= (state_q == S_PROD) && (cnt_q == 7'(SumW - 1));
      if (cfg_wr) begin
        if (paddr[2] == tct_pkg::RegTimeShift) begin
          ts_q <= pwdata[4:0];
        end else begin
          cs_q <= pwdata[5:0];
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!have_origin_q) begin
              have_origin_q <= 1'b1;
              ot_q   <= s_axis_tdata[31:0];
              oc_q   <= s_axis_tdata[79:32];
              corr_q <= '0;
              thr_q  <= '0;
              vres_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              dt_q  <= dt_c;
              de_q  <= de_c;
              x_q   <= x_c;
              y_q   <= y_c;
              cnt_q <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q <= mul_p;
          case (cnt_q)
            7'd1:    sxx_q <= sadd_r;
            7'd2:    sxy_q <= sadd_r;
            7'd3:    syy_q <= sadd_r;
            default: ;
          endcase
          if (cnt_q == 7'd3) begin
            acc_hi_q <= '0;
            acc_lo_q <= sadd_r;
            cnt_q    <= '0;
            state_q  <= S_PROD;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_PROD: begin
          acc_hi_q <= psum[SumW:1];
          acc_lo_q <= {psum[0], acc_lo_q[SumW-1:1]};
          cnt_q    <= cnt_q + 7'd1;
          if (cnt_q == 7'(SumW - 1)) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_stat.done) begin
            cnt_q <= '0;
            num_q <= '0;
            if (sq_root == '0 || dt_q == '0) begin
              corr_q  <= '0;
              thr_q   <= '0;
              vres_q  <= 1'b0;
              state_q <= S_DONE;
            end else if (sxy_q >= sq_root) begin
              corr_q  <= CorrOne;
              state_q <= S_TMUL;
            end else begin
              frem_q  <= sxy_q;
              corr_q  <= '0;
              state_q <= S_CORR;
            end
          end
        end
        S_CORR: begin
          if (frem2 >= {1'b0, sq_root}) begin
            frem_q <= SumW'(frem2 - {1'b0, sq_root});
            corr_q <= {corr_q[CorrW-2:0], 1'b1};
          end else begin
            frem_q <= frem2[SumW-1:0];
            corr_q <= {corr_q[CorrW-2:0], 1'b0};
          end
          if (cnt_q == 7'(FRAC_BITS - 1)) begin
            cnt_q   <= '0;
            state_q <= S_TMUL;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_TMUL: begin
          // de * 1e6, most significant constant bit first.
          num_q <= {num_q[NumW-2:0], 1'b0}
                 + (tct_pkg::UsecPerSec[5'(tct_pkg::UsecW - 1) - cnt_q[4:0]]
                    ? NumW'(de_q) : '0);
          if (cnt_q == 7'(tct_pkg::UsecW - 1)) begin
            cnt_q   <= '0;
            drem_q  <= '0;
            state_q <= S_TDIV;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_TDIV: begin
          drem_q <= dge ? 32'(drem2 - {1'b0, dt_q}) : drem2[31:0];
          num_q  <= num_nx;
          cnt_q  <= cnt_q + 7'd1;
          if (cnt_q == 7'(NumW - 1)) begin
            thr_q   <= (|num_nx[NumW-1:48]) ? '1 : num_nx[47:0];
            vres_q  <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_corr_q  <= corr_q;
            m_thr_q   <= thr_q;
            m_vres_q  <= vres_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = OutW'({m_thr_q, m_corr_q});
  assign m_axis_tuser[0] = m_vres_q;

  a_sqrt_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> state_q == S_SQRT)
    else $error("square root finished outside its wait state");

  a_valid_needs_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> have_origin_q)
    else $error("valid result without an origin");

  a_corr_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_corr_q <= CorrOne)
    else $error("correlation above one");

  a_sqrt_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start_q |-> !sq_stat.busy)
    else $error("square root restarted while busy");

endmodule

// ===== hw/rtl/tct_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial integer square root
// Restoring square root of a 128-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tct_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tct_pkg::RadW-1:0]     rad_i,
  output tct_pkg::sqrt_stat_t          stat_o,
  output logic [tct_pkg::SumW-1:0]     root_o
);

  localparam int RemW = tct_pkg::SumW + 2;

  logic [tct_pkg::RadW-1:0] rad_q;
  logic [RemW-1:0]          rem_q;
  logic [tct_pkg::SumW-1:0] root_q;
  logic [5:0]               cnt_q;
  logic                     busy_q;
  logic                     done_q;

  logic [RemW+1:0] tmp;
  logic [RemW+1:0] trial;
  logic            ge;

  assign tmp   = {rem_q, rad_q[tct_pkg::RadW-1 -: 2]};
  assign trial = (RemW + 2)'({root_q, 2'b01});
  assign ge    = tmp >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q <= {rad_q[tct_pkg::RadW-3:0], 2'b00};
        if (ge) begin
          rem_q  <= RemW'(tmp - trial);
          root_q <= {root_q[tct_pkg::SumW-2:0], 1'b1};
        end else begin
          rem_q  <= tmp[RemW-1:0];
          root_q <= {root_q[tct_pkg::SumW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule
